// ===== hdl/gzd_pkg.sv =====
`default_nettype none

package gzd_pkg;

  localparam int unsigned REG_W       = 12;
  localparam int unsigned VOTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_CMDS    = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_CMDS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VOTE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_MOVE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_BAND   = 2'd2;

  localparam logic [VOTE_W-1:0] RST_VOTE_DELAY = 8'd3;
  localparam logic [REG_W-1:0]  RST_HEAD_MOVE  = 12'd2;
  localparam logic [REG_W-1:0]  RST_MID_BAND   = 12'd144;
  localparam logic [VOTE_W-1:0] VOTE_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    ZONE_NONE = 2'd0,
    ZONE_TOP  = 2'd1,
    ZONE_MID  = 2'd2,
    ZONE_BOT  = 2'd3
  } zone_e;

  typedef enum logic [3:0] {
    CMD_RUN_ON     = 4'd0,
    CMD_RUN_OFF    = 4'd1,
    CMD_LEFT_ON    = 4'd2,
    CMD_LEFT_OFF   = 4'd3,
    CMD_RIGHT_ON   = 4'd4,
    CMD_RIGHT_OFF  = 4'd5,
    CMD_TAB        = 4'd6,
    CMD_SHOOT      = 4'd7,
    CMD_SHIELD     = 4'd8
  } cmd_e;

  typedef struct packed {
    cmd_e [MAX_CMDS-1:0] cmd;
    logic [CNT_W-1:0]    cnt;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/gzd_front.sv =====
`default_nettype none

module gzd_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  input  wire  [gzd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [gzd_pkg::REG_W-1:0]            cfg_data_i,
  input  wire                                  in_valid_i,
  input  wire  [COORD_BITS-1:0]                face_top_i,
  input  wire  [COORD_BITS-1:0]                face_bottom_i,
  input  wire  [COORD_BITS-1:0]                left_hand_y_i,
  input  wire  [COORD_BITS-1:0]                right_hand_y_i,
  input  gzd_pkg::q_stat_t                     q_stat_i,
  output logic                                 push_o,
  output gzd_pkg::bundle_t                     bundle_o
);
  import gzd_pkg::*;

  localparam int unsigned SW = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;

  typedef struct packed {
    zone_e             zone;
    logic [VOTE_W-1:0] votes;
  } zvote_t;

  logic [VOTE_W-1:0]     vote_delay_q;
  logic [REG_W-1:0]      head_move_q, mid_band_q;

  logic [COORD_BITS-1:0] head_prev_q, head_prev_d;
  logic                  seen_q, seen_d, run_q, run_d, rchg_q, rchg_d;
  logic [VOTE_W-1:0]     move_q, move_d, still_q, still_d;
  zvote_t                lz_q, lz_d, rz_q, rz_d;
  logic                  tl_q, tl_d, tr_q, tr_d, armed_q, armed_d;

  logic                  accept;
  logic [COORD_BITS:0]   hsum;
  logic [COORD_BITS-1:0] head, head_delta;
  logic                  moved;
  bundle_t               bnd;

  function automatic logic [VOTE_W-1:0] bump(input logic [VOTE_W-1:0] v);
    return (v == VOTE_MAX) ? v : v + 1'b1;
  endfunction

  function automatic zone_e classify(input logic [COORD_BITS-1:0] y,
                                     input logic [COORD_BITS-1:0] h,
                                     input logic [REG_W-1:0] band);
    logic [SW-1:0] lim;
    lim = SW'(h) + SW'(band);
    if (y < h) return ZONE_TOP;
    if (SW'(y) < lim) return ZONE_MID;
    return ZONE_BOT;
  endfunction

  function automatic zvote_t vote(input zone_e fresh, input zvote_t cur,
                                  input logic [VOTE_W-1:0] delay);
    zvote_t r;
    r = cur;
    r.votes = (fresh != cur.zone) ? bump(cur.votes) : '0;
    if (r.votes >= delay) begin
      r.zone  = fresh;
      r.votes = '0;
    end
    return r;
  endfunction

  assign accept     = in_valid_i && !q_stat_i.full;
  assign hsum       = {1'b0, face_top_i} + {1'b0, face_bottom_i};
  assign head       = hsum[COORD_BITS:1];
  assign head_delta = (head > head_prev_q) ? head - head_prev_q : head_prev_q - head;
  assign moved      = SW'(head_delta) > SW'(head_move_q);

  always_comb begin
    head_prev_d = head;
    seen_d      = 1'b1;
    run_d       = run_q;
    rchg_d      = rchg_q;
    move_d      = move_q;
    still_d     = still_q;
    lz_d        = lz_q;
    rz_d        = rz_q;
    tl_d        = tl_q;
    tr_d        = tr_q;
    armed_d     = armed_q;
    bnd         = '0;

    if (seen_q) begin
      if (!run_d) move_d = moved ? bump(move_d) : '0;
      else        still_d = moved ? '0 : bump(still_d);
      if (move_d >= vote_delay_q) begin
        run_d  = 1'b1;
        rchg_d = 1'b1;
        move_d = '0;
      end
      if (still_d >= vote_delay_q) begin
        run_d   = 1'b0;
        rchg_d  = 1'b1;
        still_d = '0;
      end
      lz_d = vote(classify(left_hand_y_i, head, mid_band_q), lz_q, vote_delay_q);
      rz_d = vote(classify(right_hand_y_i, head, mid_band_q), rz_q, vote_delay_q);

      // hold the pending run toggle until both hands have a zone and are not both up
      if (lz_d.zone != ZONE_NONE && rz_d.zone != ZONE_NONE &&
          !(lz_d.zone == ZONE_TOP && rz_d.zone == ZONE_TOP)) begin
        if (rchg_d) begin
          bnd.cmd[bnd.cnt[1:0]] = run_d ? CMD_RUN_ON : CMD_RUN_OFF;
          bnd.cnt = bnd.cnt + 1'b1;
          rchg_d  = 1'b0;
        end
        if (lz_d.zone == ZONE_TOP && rz_d.zone == ZONE_BOT && !tl_d && !tr_d) begin
          tl_d = 1'b1;
          bnd.cmd[bnd.cnt[1:0]] = CMD_LEFT_ON;
          bnd.cnt = bnd.cnt + 1'b1;
        end else if (lz_d.zone != ZONE_TOP && tl_d) begin
          tl_d = 1'b0;
          bnd.cmd[bnd.cnt[1:0]] = CMD_LEFT_OFF;
          bnd.cnt = bnd.cnt + 1'b1;
        end
        if (lz_d.zone == ZONE_BOT && rz_d.zone == ZONE_TOP && !tl_d && !tr_d) begin
          tr_d = 1'b1;
          bnd.cmd[bnd.cnt[1:0]] = CMD_RIGHT_ON;
          bnd.cnt = bnd.cnt + 1'b1;
        end else if (rz_d.zone != ZONE_TOP && tr_d) begin
          tr_d = 1'b0;
          bnd.cmd[bnd.cnt[1:0]] = CMD_RIGHT_OFF;
          bnd.cnt = bnd.cnt + 1'b1;
        end
        if (!run_d && bnd.cnt < CNT_W'(MAX_CMDS)) begin
          if (lz_d.zone == ZONE_BOT && rz_d.zone == ZONE_BOT) begin
            armed_d = 1'b1;
          end else if (armed_d) begin
            if (lz_d.zone == ZONE_MID && rz_d.zone == ZONE_MID) begin
              armed_d = 1'b0;
              bnd.cmd[bnd.cnt[1:0]] = CMD_TAB;
              bnd.cnt = bnd.cnt + 1'b1;
            end else if (lz_d.zone == ZONE_MID && rz_d.zone == ZONE_BOT) begin
              armed_d = 1'b0;
              bnd.cmd[bnd.cnt[1:0]] = CMD_SHOOT;
              bnd.cnt = bnd.cnt + 1'b1;
            end else if (lz_d.zone == ZONE_BOT && rz_d.zone == ZONE_MID) begin
              armed_d = 1'b0;
              bnd.cmd[bnd.cnt[1:0]] = CMD_SHIELD;
              bnd.cnt = bnd.cnt + 1'b1;
            end
          end
        end
      end
    end
  end

  assign push_o   = accept && (bnd.cnt != '0);
  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vote_delay_q <= RST_VOTE_DELAY;
      head_move_q  <= RST_HEAD_MOVE;
      mid_band_q   <= RST_MID_BAND;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOTE_DELAY: vote_delay_q <= cfg_data_i[VOTE_W-1:0];
        REG_HEAD_MOVE:  head_move_q  <= cfg_data_i;
        REG_MID_BAND:   mid_band_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_prev_q <= '0;
      seen_q      <= 1'b0;
      run_q       <= 1'b0;
      rchg_q      <= 1'b0;
      move_q      <= '0;
      still_q     <= '0;
      lz_q        <= '{zone: ZONE_NONE, votes: '0};
      rz_q        <= '{zone: ZONE_NONE, votes: '0};
      tl_q        <= 1'b0;
      tr_q        <= 1'b0;
      armed_q     <= 1'b1;
    end else if (accept) begin
      head_prev_q <= head_prev_d;
      seen_q      <= seen_d;
      run_q       <= run_d;
      rchg_q      <= rchg_d;
      move_q      <= move_d;
      still_q     <= still_d;
      lz_q        <= lz_d;
      rz_q        <= rz_d;
      tl_q        <= tl_d;
      tr_q        <= tr_d;
      armed_q     <= armed_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gzd_queue.sv =====
`default_nettype none

module gzd_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  gzd_pkg::bundle_t    push_data_i,
  input  wire                 pop_i,
  output gzd_pkg::bundle_t    pop_data_o,
  output gzd_pkg::q_stat_t    stat_o
);
  import gzd_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  bundle_t         mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_d  = push_i ? nxt(wr_q) : wr_q;
  assign rd_d  = pop_i ? nxt(rd_q) : rd_q;
  assign cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);

  assign pop_data_o   = mem[rd_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gzd_back.sv =====
`default_nettype none

module gzd_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  gzd_pkg::q_stat_t    q_stat_i,
  input  gzd_pkg::bundle_t    q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [3:0]          command_o,
  output logic                last_of_run_o
);
  import gzd_pkg::*;

  bundle_t      bnd_q;
  logic [1:0]   idx_q;
  logic         busy_q;
  logic         take, last;

  assign last  = ({1'b0, idx_q} == bnd_q.cnt - 1'b1);
  assign take  = busy_q && !out_stall_i;
  // refill the output when empty or when its final command leaves
  assign pop_o = q_stat_i.valid && (!busy_q || (take && last));

  assign out_valid_o   = busy_q;
  assign command_o     = bnd_q.cmd[idx_q];
  assign last_of_run_o = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bnd_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (last) busy_q <= 1'b0;
      idx_q <= idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gesture_zone_debouncer.sv =====
// A frame's commands are written into the command queue, then loaded into the output
// register, before the first of them is presented.
// Throughput: one frame per cycle while frames make at most one command and the output
// is not stalled; a frame with more (up to four) holds the serializer until each is sent.
// A two-entry command queue lets the classifier run ahead of the serializer.
// Reset: registers return to their defaults, tracking state clears, armed sets,
// the queue and the output register empty.
`default_nettype none

module gesture_zone_debouncer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [gzd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [gzd_pkg::REG_W-1:0]        cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [COORD_BITS-1:0]            face_top_i,
  input  wire  [COORD_BITS-1:0]            face_bottom_i,
  input  wire  [COORD_BITS-1:0]            left_hand_y_i,
  input  wire  [COORD_BITS-1:0]            right_hand_y_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [3:0]                       command_o,
  output logic                             last_of_run_o
);
  import gzd_pkg::*;

  q_stat_t q_stat;
  bundle_t push_data, pop_data;
  logic    push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat.full;

  gzd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .face_top_i     (face_top_i),
    .face_bottom_i  (face_bottom_i),
    .left_hand_y_i  (left_hand_y_i),
    .right_hand_y_i (right_hand_y_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .bundle_o       (push_data)
  );

  gzd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  gzd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .command_o     (command_o),
    .last_of_run_o (last_of_run_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.valid)
    else $error("queue pop while empty");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_run_o && !q_stat.valid) |=> !out_valid_o)
    else $error("output still valid after final command with empty queue");

  a_push_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_data.cnt != '0))
    else $error("empty command bundle pushed");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gzd_pkg::*;

  typedef struct {
    cmd_e code;
    logic last;
  } command_t;

  // Tracks head motion and hand zones frame by frame and holds the commands still owed.
  class frame_model;
    logic [7:0]  delay_cfg;
    logic [11:0] move_thr;
    logic [11:0] band_h;

    int          prev_head;
    bit          head_valid;
    bit          running;
    bit          run_pending;
    logic [7:0]  move_cnt;
    logic [7:0]  still_cnt;
    zone_e       left_zn;
    logic [7:0]  left_cnt;
    zone_e       right_zn;
    logic [7:0]  right_cnt;
    bit          turn_left;
    bit          turn_right;
    bit          standing_armed;

    command_t    owed_cmds[$];
    int          errors;

    function new();
      delay_cfg      = RST_VOTE_DELAY;
      move_thr       = RST_HEAD_MOVE;
      band_h         = RST_MID_BAND;
      prev_head      = 0;
      head_valid     = 0;
      running        = 0;
      run_pending    = 0;
      move_cnt       = '0;
      still_cnt      = '0;
      left_zn        = ZONE_NONE;
      left_cnt       = '0;
      right_zn       = ZONE_NONE;
      right_cnt      = '0;
      turn_left      = 0;
      turn_right     = 0;
      standing_armed = 1;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        REG_VOTE_DELAY: delay_cfg = val[7:0];
        REG_HEAD_MOVE:  move_thr  = val;
        REG_MID_BAND:   band_h    = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] bump(logic [7:0] v);
      return (v == VOTE_MAX) ? v : v + 8'd1;
    endfunction

    function zone_e classify(logic [11:0] y, int head);
      if (int'(y) < head) return ZONE_TOP;
      if (int'(y) < head + int'(band_h)) return ZONE_MID;
      return ZONE_BOT;
    endfunction

    function void vote_zone(zone_e fresh, inout zone_e zn, inout logic [7:0] cnt);
      cnt = (fresh != zn) ? bump(cnt) : 8'd0;
      if (cnt >= delay_cfg) begin
        zn  = fresh;
        cnt = 8'd0;
      end
    endfunction

    function int pending();
      return owed_cmds.size();
    endfunction

    function void take_frame(logic [11:0] top, logic [11:0] bot, logic [11:0] ly,
                             logic [11:0] ry);
      int       head;
      int       delta;
      bit       moved;
      cmd_e     cmds[$];
      command_t want;
      head = (int'(top) + int'(bot)) >> 1;
      if (!head_valid) begin
        head_valid = 1;
        prev_head  = head;
        return;
      end
      delta = (head > prev_head) ? head - prev_head : prev_head - head;
      moved = delta > int'(move_thr);
      if (!running) move_cnt = moved ? bump(move_cnt) : 8'd0;
      else still_cnt = moved ? 8'd0 : bump(still_cnt);
      if (move_cnt >= delay_cfg) begin
        running     = 1;
        run_pending = 1;
        move_cnt    = 8'd0;
      end
      if (still_cnt >= delay_cfg) begin
        running     = 0;
        run_pending = 1;
        still_cnt   = 8'd0;
      end
      prev_head = head;

      vote_zone(classify(ly, head), left_zn, left_cnt);
      vote_zone(classify(ry, head), right_zn, right_cnt);

      // hold any pending run toggle until both zones are known and not both raised
      if (left_zn == ZONE_NONE || right_zn == ZONE_NONE) return;
      if (left_zn == ZONE_TOP && right_zn == ZONE_TOP) return;

      if (run_pending) begin
        cmds.push_back(running ? CMD_RUN_ON : CMD_RUN_OFF);
        run_pending = 0;
      end

      if (left_zn == ZONE_TOP && right_zn == ZONE_BOT && !turn_left && !turn_right) begin
        turn_left = 1;
        cmds.push_back(CMD_LEFT_ON);
      end else if (left_zn != ZONE_TOP && turn_left) begin
        turn_left = 0;
        cmds.push_back(CMD_LEFT_OFF);
      end
      if (left_zn == ZONE_BOT && right_zn == ZONE_TOP && !turn_left && !turn_right) begin
        turn_right = 1;
        cmds.push_back(CMD_RIGHT_ON);
      end else if (right_zn != ZONE_TOP && turn_right) begin
        turn_right = 0;
        cmds.push_back(CMD_RIGHT_OFF);
      end

      if (!running && cmds.size() < MAX_CMDS) begin
        if (left_zn == ZONE_BOT && right_zn == ZONE_BOT) begin
          standing_armed = 1;
        end else if (standing_armed) begin
          if (left_zn == ZONE_MID && right_zn == ZONE_MID) begin
            standing_armed = 0;
            cmds.push_back(CMD_TAB);
          end else if (left_zn == ZONE_MID && right_zn == ZONE_BOT) begin
            standing_armed = 0;
            cmds.push_back(CMD_SHOOT);
          end else if (left_zn == ZONE_BOT && right_zn == ZONE_MID) begin
            standing_armed = 0;
            cmds.push_back(CMD_SHIELD);
          end
        end
      end

      foreach (cmds[k]) begin
        want.code = cmds[k];
        want.last = (k == cmds.size() - 1);
        owed_cmds.push_back(want);
      end
    endfunction

    function void match_command(logic [3:0] code, logic last);
      command_t want;
      if (owed_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %0d last %0b",
                 $time, code, last);
        errors++;
        return;
      end
      want = owed_cmds.pop_front();
      if (code !== want.code) begin
        $display("%0t: command mismatch, expected %0d (%s), actual %0d",
                 $time, want.code, want.code.name(), code);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last flag mismatch, expected %0b, actual %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [11:0]          face_top;
  logic [11:0]          face_bottom;
  logic [11:0]          left_y;
  logic [11:0]          right_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [3:0]           command;
  logic                 last_flag;

  frame_model     tracker;
  bit             tx_calm;
  bit             rx_calm;
  int             stall_left;
  int             cur_head;

  int vd_set[6]    = '{3, 1, 0, 2, 255, 4};
  int thr_set[6]   = '{2, 0, 4095, 20, 10, 1};
  int band_set[6]  = '{144, 0, 4095, 300, 200, 300};
  int count_set[6] = '{40, 30, 20, 40, 12, 40};

  gesture_zone_debouncer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .face_top_i     (face_top),
    .face_bottom_i  (face_bottom),
    .left_hand_y_i  (left_y),
    .right_hand_y_i (right_y),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .command_o      (command),
    .last_of_run_o  (last_flag)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver back-pressure: a fresh stall length is drawn after every accepted command.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      out_stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.match_command(command, last_flag);
      stall_left = rx_calm ? 0 : $urandom_range(4, 0);
    end
  end

  function automatic int lesser(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [11:0] hand_row(zone_e z, int head);
    int band;
    band = int'(tracker.band_h);
    case (z)
      ZONE_TOP: if (head > 0) return 12'($urandom_range(head - 1, 0));
      ZONE_MID: if (band > 0 && head <= 4095)
                  return 12'($urandom_range(lesser(head + band - 1, 4095), head));
      ZONE_BOT: if (head + band <= 4095) return 12'($urandom_range(4095, head + band));
      default: ;
    endcase
    // zone not reachable at this head position
    return 12'($urandom_range(4095, 0));
  endfunction

  task automatic send_frame(input logic [11:0] top, input logic [11:0] bot,
                            input logic [11:0] ly, input logic [11:0] ry);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    face_top    = top;
    face_bottom = bot;
    left_y      = ly;
    right_y     = ry;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_frame(top, bot, ly, ry);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, wait for every owed command, then let the pipeline run dry.
  task automatic settle();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic hold_gesture(input zone_e lz, input zone_e rz, input int moving,
                              input int frames);
    int thr;
    int d;
    int s;
    int top;
    int bot;
    thr = int'(tracker.move_thr);
    repeat (frames) begin
      if (moving != 0) d = (thr < 4095) ? $urandom_range(lesser(thr + 64, 4095), thr + 1) : 0;
      else d = $urandom_range(lesser(thr, 3), 0);
      if (cur_head + d <= 4095 && (cur_head < d || $urandom_range(1, 0)))
        cur_head += d;
      else if (cur_head >= d)
        cur_head -= d;
      s   = $urandom_range(lesser(cur_head, 4095 - cur_head), 0);
      top = cur_head - s;
      bot = cur_head + s;
      if (bot < 4095 && $urandom_range(1, 0)) bot++;
      send_frame(12'(top), 12'(bot), hand_row(lz, cur_head), hand_row(rz, cur_head));
    end
  endtask

  task automatic random_frames(input int count);
    int         sent;
    int         pick;
    int         len;
    int         cap;
    int         hi;
    logic [11:0] t;
    logic [11:0] b;
    zone_e      lz;
    zone_e      rz;
    sent = 0;
    cap  = lesser(int'(tracker.delay_cfg), 5);
    hi   = 4095 - int'(tracker.band_h) - 1;
    cur_head = $urandom_range((hi < 1) ? 1 : hi, 1);
    while (sent < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        t = 12'($urandom_range(4095, 0));
        b = 12'($urandom_range(4095, 0));
        send_frame(t, b, 12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)));
        cur_head = (int'(t) + int'(b)) >> 1;
        sent++;
      end else begin
        lz  = zone_e'($urandom_range(3, 1));
        rz  = zone_e'($urandom_range(3, 1));
        // short holds break the vote run; long ones let the zones settle
        len = (pick < 25) ? 1 : $urandom_range(cap + 2, 1);
        hold_gesture(lz, rz, $urandom_range(1, 0), len);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_VOTE_DELAY;
    cfg_data    = '0;
    in_valid    = 1'b0;
    face_top    = '0;
    face_bottom = '0;
    left_y      = '0;
    right_y     = '0;
    tx_calm     = 0;
    rx_calm     = 0;
    cur_head    = 0;
    tracker     = new();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // first frame only latches the head; the next ones vote zones from nothing
    send_frame(12'd0, 12'd0, 12'd0, 12'd0);
    send_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_frame(12'hAAA, 12'h555, 12'hAAA, 12'h555);
    cur_head = (12'hAAA + 12'h555) >> 1;
    // run switches on while both hands are raised, so the toggle waits
    hold_gesture(ZONE_TOP, ZONE_TOP, 1, 2);
    hold_gesture(ZONE_MID, ZONE_MID, 0, 3);

    settle();
    write_reg(REG_VOTE_DELAY, 12'd1);
    hold_gesture(ZONE_BOT, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_MID, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_BOT, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_BOT, ZONE_MID, 0, 1);
    hold_gesture(ZONE_MID, ZONE_MID, 0, 1);
    hold_gesture(ZONE_BOT, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_MID, ZONE_MID, 0, 1);
    hold_gesture(ZONE_TOP, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_MID, ZONE_MID, 0, 1);
    hold_gesture(ZONE_BOT, ZONE_TOP, 0, 1);
    hold_gesture(ZONE_TOP, ZONE_TOP, 0, 1);
    hold_gesture(ZONE_BOT, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_TOP, ZONE_BOT, 0, 1);
    hold_gesture(ZONE_BOT, ZONE_TOP, 1, 1);
    hold_gesture(ZONE_MID, ZONE_BOT, 0, 1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      tx_calm = (ph % 3 == 1);
      rx_calm = (ph % 3 == 2);
      // the top nibble of the delay register is don't-care
      write_reg(REG_VOTE_DELAY, (vd_set[ph] == 255) ? 12'hFFF : REG_W'(vd_set[ph]));
      write_reg(REG_HEAD_MOVE, REG_W'(thr_set[ph]));
      write_reg(REG_MID_BAND, REG_W'(band_set[ph]));
      random_frames(count_set[ph]);
    end

    settle();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
